@@ hw/rtl/flpt_pkg.sv @@
// Shared types and constants for the FIFO live-page tracker.
// It has no dependencies. The controller, the datapath and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package flpt_pkg;

  localparam int ROOT_W         = 44;
  localparam int VADDR_W        = 38;
  localparam int OWNER_W        = 6;
  localparam int LIMIT_W        = 7;
  localparam int KIND_W         = 2;
  localparam int DEF_LIVE_SLOTS = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    K_EVICT     = 2'd0,
    K_ADD       = 2'd1,
    K_REMOVED   = 2'd2,
    K_NOT_FOUND = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_ADD    = 2'd1,
    S_MATCH  = 2'd2,
    S_REMOVE = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic evict;
    logic append;
    logic match;
    logic remove;
  } cmd_t;

  typedef struct packed {
    logic evict_needed;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/flpt_ctrl.sv @@
// Controller state machine for the live-page tracker.
// It depends on flpt_pkg and issues commands to flpt_dpath.
`timescale 1ns / 1ps
`default_nettype none

module flpt_ctrl import flpt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   in_req_type,
  input  wire sts_t   sts,
  output cmd_t        cmd,
  output logic        busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_req_type == REQ_ADD) ? S_ADD : S_MATCH;
        end
      end
      S_ADD: begin
        if (!sts.evict_needed) begin
          state_nxt = S_IDLE;
        end
      end
      S_MATCH: begin
        state_nxt = S_REMOVE;
      end
      S_REMOVE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_ADD: begin
        cmd.evict  = sts.evict_needed;
        cmd.append = !sts.evict_needed;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.evict, cmd.append, cmd.match, cmd.remove}))
    else $error("More than one datapath command in a cycle.");

  a_match_then_remove: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> cmd.remove)
    else $error("A match was not followed by its removal step.");

  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> busy)
    else $error("The block was not busy after taking a request.");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/flpt_dpath.sv @@
// Datapath of the live-page tracker: the row of page cells, the match vector and the result register.
// It depends on flpt_pkg and is driven by flpt_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module flpt_dpath import flpt_pkg::*; #(
  parameter int LIVE_SLOTS = DEF_LIVE_SLOTS,
  parameter int CNT_W      = $clog2(LIVE_SLOTS + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [ROOT_W-1:0]    in_page_root,
  input  wire logic [VADDR_W-1:0]   in_virt_addr,
  input  wire logic [OWNER_W-1:0]   in_owner_pid,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIMIT_W-1:0]   cfg_live_limit,
  output logic                      out_valid,
  output logic [KIND_W-1:0]         out_kind,
  output logic [ROOT_W-1:0]         out_page_root_res,
  output logic [VADDR_W-1:0]        out_virt_addr_res,
  output logic [OWNER_W-1:0]        out_owner_pid_res,
  output logic [CNT_W-1:0]          out_live_count,
  output logic                      out_last
);

  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [ROOT_W-1:0]  root_r   [LIVE_SLOTS];
  logic [ROOT_W-1:0]  root_nxt [LIVE_SLOTS];
  logic [VADDR_W-1:0] vaddr_r  [LIVE_SLOTS];
  logic [VADDR_W-1:0] vaddr_nxt[LIVE_SLOTS];
  logic [OWNER_W-1:0] owner_r  [LIVE_SLOTS];
  logic [OWNER_W-1:0] owner_nxt[LIVE_SLOTS];

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   evicted_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [ROOT_W-1:0]  req_root_r;
  logic [VADDR_W-1:0] req_vaddr_r;
  logic [OWNER_W-1:0] req_owner_r;
  logic [LIVE_SLOTS-1:0] match_r;
  logic [LIVE_SLOTS-1:0] match_nxt;
  logic [LIVE_SLOTS-1:0] past_hit;
  logic [LIVE_SLOTS-1:0] first_hit;
  logic [OWNER_W-1:0]    hit_owner;
  logic                  found;
  logic [CMP_W-1:0]      lim_eff;
  logic [CNT_W-1:0]      count_dec;
  logic [CNT_W-1:0]      count_app;

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [ROOT_W-1:0]  out_root_r;
  logic [VADDR_W-1:0] out_vaddr_r;
  logic [OWNER_W-1:0] out_owner_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_last_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    lim_eff = CMP_W'(limit_r);
    if (lim_eff == '0) begin
      lim_eff = CMP_W'(1);
    end else if (lim_eff > CMP_W'(LIVE_SLOTS)) begin
      lim_eff = CMP_W'(LIVE_SLOTS);
    end
  end

  assign sts.evict_needed = (CMP_W'(count_r) >= lim_eff) && (count_r != '0) &&
                            (evicted_r != CNT_W'(LIVE_SLOTS - 1));

  assign count_dec = count_r - CNT_W'(1);
  assign count_app = (count_r == CNT_W'(LIVE_SLOTS)) ? count_r : count_r + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      match_nxt[i] = (CNT_W'(i) < count_r) && (root_r[i] == req_root_r) &&
                     (vaddr_r[i] == req_vaddr_r);
    end
  end

  always_comb begin
    logic [LIVE_SLOTS-1:0] low_mask;
    hit_owner = '0;
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      low_mask    = {LIVE_SLOTS{1'b1}} >> (LIVE_SLOTS - 1 - i);
      past_hit[i] = |(match_r & low_mask);
    end
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      if (i == 0) begin
        first_hit[i] = past_hit[i];
      end else begin
        first_hit[i] = past_hit[i] && !past_hit[i-1];
      end
      hit_owner = hit_owner | (owner_r[i] & {OWNER_W{first_hit[i]}});
    end
    found = past_hit[LIVE_SLOTS-1];
  end

  always_comb begin
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      root_nxt[i]  = root_r[i];
      vaddr_nxt[i] = vaddr_r[i];
      owner_nxt[i] = owner_r[i];
      if ((cmd.evict || (cmd.remove && past_hit[i])) && (i < LIVE_SLOTS - 1)) begin
        root_nxt[i]  = root_r[(i + 1) % LIVE_SLOTS];
        vaddr_nxt[i] = vaddr_r[(i + 1) % LIVE_SLOTS];
        owner_nxt[i] = owner_r[(i + 1) % LIVE_SLOTS];
      end
      if (cmd.append && (CNT_W'(i) == count_r)) begin
        root_nxt[i]  = req_root_r;
        vaddr_nxt[i] = req_vaddr_r;
        owner_nxt[i] = req_owner_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      root_r[i]  <= root_nxt[i];
      vaddr_r[i] <= vaddr_nxt[i];
      owner_r[i] <= owner_nxt[i];
    end
    if (cmd.match) begin
      match_r <= match_nxt;
    end
    if (cmd.capture) begin
      req_root_r  <= in_page_root;
      req_vaddr_r <= in_virt_addr;
      req_owner_r <= in_owner_pid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      evicted_r <= '0;
      limit_r   <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_live_limit;
      end
      if (cmd.capture) begin
        evicted_r <= '0;
      end else if (cmd.evict) begin
        evicted_r <= evicted_r + CNT_W'(1);
      end
      if (cmd.evict || (cmd.remove && found)) begin
        count_r <= count_dec;
      end else if (cmd.append) begin
        count_r <= count_app;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.evict || cmd.append || cmd.remove;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evict) begin
      out_kind_r  <= K_EVICT;
      out_root_r  <= root_r[0];
      out_vaddr_r <= vaddr_r[0];
      out_owner_r <= owner_r[0];
      out_count_r <= count_dec;
      out_last_r  <= 1'b0;
    end else if (cmd.append) begin
      out_kind_r  <= K_ADD;
      out_root_r  <= req_root_r;
      out_vaddr_r <= req_vaddr_r;
      out_owner_r <= req_owner_r;
      out_count_r <= count_app;
      out_last_r  <= 1'b1;
    end else if (cmd.remove) begin
      out_kind_r  <= found ? K_REMOVED : K_NOT_FOUND;
      out_root_r  <= req_root_r;
      out_vaddr_r <= req_vaddr_r;
      out_owner_r <= found ? hit_owner : '0;
      out_count_r <= found ? count_dec : count_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_page_root_res = out_root_r;
  assign out_virt_addr_res = out_vaddr_r;
  assign out_owner_pid_res = out_owner_r;
  assign out_live_count    = out_count_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIVE_SLOTS))
    else $error("The live count exceeds the number of cells.");

  a_evict_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("An eviction did not lower the live count by one.");

  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == K_EVICT)) |-> !out_last_r)
    else $error("An eviction result was marked as the final result.");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/fifo_live_page_tracker_core.sv @@
// An add request is captured, then evicts the oldest entries one at a time while the table is
// at its limit, and then appends its page. A remove request is captured, matched and removed.
// A new request is accepted only once the block is idle again after the previous request.
// The match over all cells is registered before the removal cycle.
// Reset is synchronous and active low. It empties the table and sets the limit to 50.
// Results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module fifo_live_page_tracker_core import flpt_pkg::*; #(
  parameter int LIVE_SLOTS = DEF_LIVE_SLOTS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_req_type,
  input  wire logic [ROOT_W-1:0]                   in_page_root,
  input  wire logic [VADDR_W-1:0]                  in_virt_addr,
  input  wire logic [OWNER_W-1:0]                  in_owner_pid,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [LIMIT_W-1:0]                  cfg_live_limit,
  output logic                                     out_valid,
  output logic [KIND_W-1:0]                        out_kind,
  output logic [ROOT_W-1:0]                        out_page_root_res,
  output logic [VADDR_W-1:0]                       out_virt_addr_res,
  output logic [OWNER_W-1:0]                       out_owner_pid_res,
  output logic [$clog2(LIVE_SLOTS + 1)-1:0]        out_live_count,
  output logic                                     out_last
);

  localparam int CNT_W = $clog2(LIVE_SLOTS + 1);

  cmd_t cmd;
  sts_t sts;

  flpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  flpt_dpath #(
    .LIVE_SLOTS (LIVE_SLOTS),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_page_root      (in_page_root),
    .in_virt_addr      (in_virt_addr),
    .in_owner_pid      (in_owner_pid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_live_limit    (cfg_live_limit),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_page_root_res (out_page_root_res),
    .out_virt_addr_res (out_virt_addr_res),
    .out_owner_pid_res (out_owner_pid_res),
    .out_live_count    (out_live_count),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the FIFO live-page tracker core.
// It depends on flpt_pkg and fifo_live_page_tracker_core, and keeps its own table model
// that predicts every eviction, add, removal and not-found result of each request.
`timescale 1ns / 1ps

module tb_top;
  import flpt_pkg::*;

  localparam int SLOTS       = DEF_LIVE_SLOTS;
  localparam int COUNT_W     = $clog2(SLOTS + 1);
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    kind_t                kind;
    logic [ROOT_W-1:0]    root;
    logic [VADDR_W-1:0]   vaddr;
    logic [OWNER_W-1:0]   owner;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } page_event_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_req_type;
  logic [ROOT_W-1:0]    in_page_root;
  logic [VADDR_W-1:0]   in_virt_addr;
  logic [OWNER_W-1:0]   in_owner_pid;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_live_limit;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [ROOT_W-1:0]    out_page_root_res;
  logic [VADDR_W-1:0]   out_virt_addr_res;
  logic [OWNER_W-1:0]   out_owner_pid_res;
  logic [COUNT_W-1:0]   out_live_count;
  logic                 out_last;

  logic [ROOT_W-1:0]    tbl_root  [SLOTS];
  logic [VADDR_W-1:0]   tbl_vaddr [SLOTS];
  logic [OWNER_W-1:0]   tbl_owner [SLOTS];
  int                   tbl_count;
  logic [LIMIT_W-1:0]   tbl_limit;

  page_event_t          page_events_due [$];
  logic [ROOT_W-1:0]    root_pool  [8];
  logic [VADDR_W-1:0]   vaddr_pool [8];
  int unsigned          mismatch_count;
  int unsigned          cycle_count;
  int                   burst_left;

  fifo_live_page_tracker_core #(
    .LIVE_SLOTS(SLOTS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_page_root      (in_page_root),
    .in_virt_addr      (in_virt_addr),
    .in_owner_pid      (in_owner_pid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_live_limit    (cfg_live_limit),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_page_root_res (out_page_root_res),
    .out_virt_addr_res (out_virt_addr_res),
    .out_owner_pid_res (out_owner_pid_res),
    .out_live_count    (out_live_count),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
               what, cycle_count, got, want);
    end
  endtask

  always @(posedge clk) begin : check_results
    page_event_t want;
    if (rst_n && out_valid) begin
      if (page_events_due.size() == 0) begin
        report_mismatch("result with no request pending", out_kind, 0);
      end else begin
        want = page_events_due.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_page_root_res !== want.root)
          report_mismatch("page_root_res", out_page_root_res, want.root);
        if (out_virt_addr_res !== want.vaddr)
          report_mismatch("virt_addr_res", out_virt_addr_res, want.vaddr);
        if (out_owner_pid_res !== want.owner)
          report_mismatch("owner_pid_res", out_owner_pid_res, want.owner);
        if (out_live_count !== want.count)
          report_mismatch("live_count", out_live_count, want.count);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  task automatic drop_table_entry(input int idx);
    for (int i = idx; i + 1 < tbl_count; i++) begin
      tbl_root[i]  = tbl_root[i + 1];
      tbl_vaddr[i] = tbl_vaddr[i + 1];
      tbl_owner[i] = tbl_owner[i + 1];
    end
    tbl_count--;
  endtask

  task automatic track_page_request(input logic rt, input logic [ROOT_W-1:0] root,
                                    input logic [VADDR_W-1:0] va,
                                    input logic [OWNER_W-1:0] own);
    int          lim;
    int          evicted;
    bit          found;
    page_event_t ev;
    if (rt == REQ_ADD) begin
      lim = tbl_limit;
      if (lim == 0) lim = 1;
      if (lim > SLOTS) lim = SLOTS;
      evicted = 0;
      // A single add never evicts more than all but one entry.
      while (tbl_count >= lim && tbl_count > 0 && evicted < SLOTS - 1) begin
        ev.kind  = K_EVICT;
        ev.root  = tbl_root[0];
        ev.vaddr = tbl_vaddr[0];
        ev.owner = tbl_owner[0];
        drop_table_entry(0);
        ev.count = COUNT_W'(tbl_count);
        ev.last  = 1'b0;
        page_events_due.push_back(ev);
        evicted++;
      end
      if (tbl_count < SLOTS) begin
        tbl_root[tbl_count]  = root;
        tbl_vaddr[tbl_count] = va;
        tbl_owner[tbl_count] = own;
        tbl_count++;
      end
      ev.kind  = K_ADD;
      ev.root  = root;
      ev.vaddr = va;
      ev.owner = own;
      ev.count = COUNT_W'(tbl_count);
      ev.last  = 1'b1;
      page_events_due.push_back(ev);
    end else begin
      found = 1'b0;
      ev.root  = root;
      ev.vaddr = va;
      ev.last  = 1'b1;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_root[i] == root && tbl_vaddr[i] == va) begin
          ev.owner = tbl_owner[i];
          drop_table_entry(i);
          found = 1'b1;
          break;
        end
      end
      if (found) begin
        ev.kind = K_REMOVED;
      end else begin
        ev.kind  = K_NOT_FOUND;
        ev.owner = '0;
      end
      ev.count = COUNT_W'(tbl_count);
      page_events_due.push_back(ev);
    end
  endtask

  task automatic send_page_req(input logic rt, input logic [ROOT_W-1:0] root,
                               input logic [VADDR_W-1:0] va,
                               input logic [OWNER_W-1:0] own);
    @(negedge clk);
    start        = 1'b1;
    in_req_type  = rt;
    in_page_root = root;
    in_virt_addr = va;
    in_owner_pid = own;
    do @(posedge clk); while (busy);
    track_page_request(rt, root, va, own);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle_table();
    @(negedge clk);
    start = 1'b0;
    while (page_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_live_limit(input logic [LIMIT_W-1:0] limit);
    @(negedge clk);
    cfg_valid      = 1'b1;
    cfg_live_limit = limit;
    do @(posedge clk); while (!cfg_ready);
    tbl_limit = limit;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [ROOT_W-1:0] rand_root();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ROOT_W-1:0];
  endfunction

  function automatic logic [VADDR_W-1:0] rand_vaddr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[VADDR_W-1:0];
  endfunction

  // Removes mostly target resident pages; some miss by one address bit or are unrelated.
  task automatic pick_page_req(input int add_pct, output logic rt,
                               output logic [ROOT_W-1:0] root,
                               output logic [VADDR_W-1:0] va,
                               output logic [OWNER_W-1:0] own);
    int k;
    rt  = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_REMOVE;
    own = OWNER_W'($urandom());
    if (rt == REQ_REMOVE && tbl_count > 0 && $urandom_range(9) < 7) begin
      k    = $urandom_range(tbl_count - 1);
      root = tbl_root[k];
      va   = tbl_vaddr[k];
      if ($urandom_range(5) == 0) va = va ^ (VADDR_W'(1) << $urandom_range(VADDR_W - 1));
    end else begin
      root = ($urandom_range(3) == 0) ? rand_root() : root_pool[$urandom_range(7)];
      va   = ($urandom_range(3) == 0) ? rand_vaddr() : vaddr_pool[$urandom_range(7)];
    end
  endtask

  task automatic run_page_stream(input int count, input int add_pct);
    logic                rt;
    logic [ROOT_W-1:0]   root;
    logic [VADDR_W-1:0]  va;
    logic [OWNER_W-1:0]  own;
    for (int n = 0; n < count; n++) begin
      pick_page_req(add_pct, rt, root, va, own);
      send_page_req(rt, root, va, own);
      burst_left--;
      if (burst_left <= 0) begin
        hold_off($urandom_range(1, 8));
        burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_page_req(REQ_REMOVE, '0, '0, '0);
    send_page_req(REQ_ADD, '1, '1, '1);
    send_page_req(REQ_ADD, '0, '0, '0);
    send_page_req(REQ_ADD, '1, '1, OWNER_W'(5));
    send_page_req(REQ_ADD, '1, '0, OWNER_W'(42));
    send_page_req(REQ_REMOVE, '1, '1, '0);
    send_page_req(REQ_REMOVE, '1, '1, '1);
    send_page_req(REQ_REMOVE, '1, '1, '0);
    send_page_req(REQ_REMOVE, '0, '1, '0);
    send_page_req(REQ_REMOVE, '0, '0, '1);
    settle_table();
  endtask

  task automatic test_limit_edges();
    write_live_limit(LIMIT_W'(1));
    send_page_req(REQ_ADD, ROOT_W'(44'h123), VADDR_W'(38'h456), OWNER_W'(1));
    send_page_req(REQ_ADD, ROOT_W'(44'hABC), VADDR_W'(38'hDEF), OWNER_W'(2));
    settle_table();
    write_live_limit('0);
    send_page_req(REQ_ADD, ROOT_W'(44'h777), VADDR_W'(38'h888), OWNER_W'(3));
    send_page_req(REQ_REMOVE, ROOT_W'(44'h777), VADDR_W'(38'h888), '0);
    send_page_req(REQ_ADD, rand_root(), rand_vaddr(), OWNER_W'(4));
    settle_table();
    write_live_limit(LIMIT_W'(2));
    send_page_req(REQ_ADD, rand_root(), rand_vaddr(), OWNER_W'(6));
    send_page_req(REQ_ADD, rand_root(), rand_vaddr(), OWNER_W'(7));
    settle_table();
  endtask

  task automatic test_full_table();
    write_live_limit('1);
    run_page_stream(70, 100);
    settle_table();
    // Dropping the limit under a full table forces the longest eviction run.
    write_live_limit(LIMIT_W'(1));
    send_page_req(REQ_ADD, rand_root(), rand_vaddr(), OWNER_W'($urandom()));
    send_page_req(REQ_ADD, rand_root(), rand_vaddr(), OWNER_W'($urandom()));
    settle_table();
    write_live_limit(LIMIT_W'(SLOTS));
    run_page_stream(30, 60);
    settle_table();
  endtask

  task automatic test_random_traffic();
    root_pool[0]  = '1;
    vaddr_pool[0] = '1;
    root_pool[1]  = '0;
    vaddr_pool[1] = '0;
    for (int i = 2; i < 8; i++) begin
      root_pool[i]  = rand_root();
      vaddr_pool[i] = rand_vaddr();
    end
    write_live_limit(LIMIT_RESET);
    run_page_stream(55, 65);
    settle_table();
    write_live_limit(LIMIT_W'($urandom_range(2, 8)));
    run_page_stream(55, 55);
    settle_table();
    write_live_limit(LIMIT_W'(SLOTS));
    run_page_stream(55, 70);
    settle_table();
    write_live_limit(LIMIT_W'($urandom_range(9, 127)));
    run_page_stream(55, 60);
    settle_table();
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req_type    = REQ_ADD;
    in_page_root   = '0;
    in_virt_addr   = '0;
    in_owner_pid   = '0;
    cfg_valid      = 1'b0;
    cfg_live_limit = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 1;
    tbl_count      = 0;
    tbl_limit      = LIMIT_RESET;
    for (int i = 0; i < 8; i++) begin
      root_pool[i]  = rand_root();
      vaddr_pool[i] = rand_vaddr();
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_limit_edges();
    test_full_table();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/flpt_pkg.sv
hw/rtl/flpt_ctrl.sv
hw/rtl/flpt_dpath.sv
hw/rtl/fifo_live_page_tracker_core.sv
dv/tb_top.sv
